// ----- src/tkn_pkg.sv -----
// Shared types, codes and helpers for the top-k candidate table.
// No dependencies; imported by every other file of the block but tkn_ram.
package tkn_pkg;

  localparam int SCORE_W    = 16;
  localparam int COORD_W    = 12;
  localparam int OP_W       = 2;
  localparam int ACT_W      = 4;
  localparam int ROIS_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [SCORE_W-1:0] MIN_SCORE_RST = 16'sd100;
  localparam logic [ROIS_W-1:0]         MAX_ROIS_RST  = 5'd4;

  typedef enum logic [OP_W-1:0] {
    OP_OFFER = 2'd0,
    OP_DUMP  = 2'd1,
    OP_CLEAR = 2'd2
  } tkn_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SCORE = 1'b0,
    REG_MAX_ROIS  = 1'b1
  } tkn_reg_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_BELOW_MIN      = 4'd0,
    ACT_DOMINATED      = 4'd1,
    ACT_APPENDED       = 4'd2,
    ACT_REPLACED_WORST = 4'd3,
    ACT_FULL_DROPPED   = 4'd4,
    ACT_REPLACED_ONE   = 4'd5,
    ACT_MERGED         = 4'd6,
    ACT_ENTRY          = 4'd7,
    ACT_EMPTY          = 4'd8,
    ACT_CLEARED        = 4'd9
  } tkn_action_t;

  // x in the low bits, then y, w, h
  typedef struct packed {
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } tkn_rect_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    tkn_rect_t                 rect;
  } tkn_entry_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    tkn_entry_t      cand;
  } tkn_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_COMPACT,
    ST_EMIT,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } tkn_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RESULT,
    CMD_SCAN,
    CMD_COMPACT_START,
    CMD_COMPACT,
    CMD_PLACE,
    CMD_CLEAR,
    CMD_EMIT,
    CMD_DUMP_RD,
    CMD_DUMP_OUT
  } tkn_cmd_kind_t;

  typedef enum logic [1:0] {
    PL_APPEND,
    PL_WORST,
    PL_FIRST,
    PL_MERGE
  } tkn_place_t;

  typedef struct packed {
    tkn_cmd_kind_t kind;
    tkn_action_t   act;
    tkn_place_t    place;
  } tkn_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            below_min;
    logic            dominated;
    logic            pass_done;
    logic            none_beaten;
    logic            one_beaten;
    logic            fill_lt_limit;
    logic            have_worst;
    logic            fill_zero;
    logic            out_free;
    logic            dump_last;
  } tkn_status_t;

  function automatic int tkn_idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int tkn_cnt_bits(input int n);
    return $clog2(n + 1);
  endfunction

  // Interiors share a pixel; a zero width or height overlaps nothing.
  function automatic logic tkn_overlap(input tkn_rect_t a, input tkn_rect_t b);
    logic [COORD_W:0] a_xe;
    logic [COORD_W:0] a_ye;
    logic [COORD_W:0] b_xe;
    logic [COORD_W:0] b_ye;
    logic             empty;
    a_xe  = {1'b0, a.x} + {1'b0, a.w};
    a_ye  = {1'b0, a.y} + {1'b0, a.h};
    b_xe  = {1'b0, b.x} + {1'b0, b.w};
    b_ye  = {1'b0, b.y} + {1'b0, b.h};
    empty = (a.w == '0) || (a.h == '0) || (b.w == '0) || (b.h == '0);
    return !empty && ({1'b0, a.x} < b_xe) && ({1'b0, b.x} < a_xe) &&
           ({1'b0, a.y} < b_ye) && ({1'b0, b.y} < a_ye);
  endfunction

endpackage

// ----- src/tkn_if.sv -----
// Valid/ready channel interfaces: candidate input, result output, config writes.
// Depends on tkn_pkg.
interface tkn_in_if import tkn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [SCORE_W-1:0] cand_score;
  logic [COORD_W-1:0]        cand_x;
  logic [COORD_W-1:0]        cand_y;
  logic [COORD_W-1:0]        cand_w;
  logic [COORD_W-1:0]        cand_h;

  modport source (output valid, op, cand_score, cand_x, cand_y, cand_w, cand_h,
                  input ready);
  modport sink   (input valid, op, cand_score, cand_x, cand_y, cand_w, cand_h,
                  output ready);
endinterface

interface tkn_out_if import tkn_pkg::*; #(parameter int MAX_ENTRIES = 16) ();
  localparam int IDX_W = tkn_idx_bits(MAX_ENTRIES);
  localparam int CNT_W = tkn_cnt_bits(MAX_ENTRIES);

  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic [IDX_W-1:0]          slot;
  logic signed [SCORE_W-1:0] entry_score;
  logic [COORD_W-1:0]        entry_x;
  logic [COORD_W-1:0]        entry_y;
  logic [COORD_W-1:0]        entry_w;
  logic [COORD_W-1:0]        entry_h;
  logic [CNT_W-1:0]          entry_count;
  logic                      last;

  modport source (output valid, action, slot, entry_score, entry_x, entry_y, entry_w,
                  entry_h, entry_count, last, input ready);
  modport sink   (input valid, action, slot, entry_score, entry_x, entry_y, entry_w,
                  entry_h, entry_count, last, output ready);
endinterface

interface tkn_cfg_if import tkn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/tkn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tkn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- src/tkn_ctrl.sv -----
// Sequencing state machine of the candidate table: issues datapath commands.
// Depends on tkn_pkg.
module tkn_ctrl import tkn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tkn_status_t sts,
  output tkn_cmd_t    cmd
);

  tkn_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        case (sts.op)
          OP_OFFER: state_nxt = sts.below_min ? ST_EMIT : ST_SCAN;
          OP_DUMP:  state_nxt = sts.fill_zero ? ST_EMIT : ST_DUMP_RD;
          OP_CLEAR: state_nxt = ST_EMIT;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (sts.dominated)      state_nxt = ST_EMIT;
        else if (sts.pass_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.none_beaten || sts.one_beaten) state_nxt = ST_EMIT;
        else                                   state_nxt = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (sts.pass_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_DUMP_RD: state_nxt = ST_DUMP_OUT;
      ST_DUMP_OUT: begin
        if (sts.out_free) state_nxt = sts.dump_last ? ST_IDLE : ST_DUMP_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.kind  = CMD_NONE;
    cmd.act   = ACT_BELOW_MIN;
    cmd.place = PL_APPEND;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.kind = CMD_LOAD;
      end
      ST_CHECK: begin
        case (sts.op)
          OP_OFFER: begin
            if (sts.below_min) begin
              cmd.kind = CMD_RESULT;
              cmd.act  = ACT_BELOW_MIN;
            end
          end
          OP_DUMP: begin
            if (sts.fill_zero) begin
              cmd.kind = CMD_RESULT;
              cmd.act  = ACT_EMPTY;
            end
          end
          OP_CLEAR: begin
            cmd.kind = CMD_CLEAR;
            cmd.act  = ACT_CLEARED;
          end
          default: cmd.kind = CMD_NONE;
        endcase
      end
      ST_SCAN: begin
        if (sts.dominated) begin
          cmd.kind = CMD_RESULT;
          cmd.act  = ACT_DOMINATED;
        end else begin
          cmd.kind = CMD_SCAN;
        end
      end
      ST_DECIDE: begin
        if (sts.none_beaten) begin
          if (sts.fill_lt_limit) begin
            cmd.kind  = CMD_PLACE;
            cmd.place = PL_APPEND;
            cmd.act   = ACT_APPENDED;
          end else if (sts.have_worst) begin
            cmd.kind  = CMD_PLACE;
            cmd.place = PL_WORST;
            cmd.act   = ACT_REPLACED_WORST;
          end else begin
            cmd.kind = CMD_RESULT;
            cmd.act  = ACT_FULL_DROPPED;
          end
        end else if (sts.one_beaten) begin
          cmd.kind  = CMD_PLACE;
          cmd.place = PL_FIRST;
          cmd.act   = ACT_REPLACED_ONE;
        end else begin
          cmd.kind = CMD_COMPACT_START;
        end
      end
      ST_COMPACT: begin
        if (sts.pass_done) begin
          cmd.kind  = CMD_PLACE;
          cmd.place = PL_MERGE;
          cmd.act   = ACT_MERGED;
        end else begin
          cmd.kind = CMD_COMPACT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) cmd.kind = CMD_EMIT;
      end
      ST_DUMP_RD: cmd.kind = CMD_DUMP_RD;
      ST_DUMP_OUT: begin
        if (sts.out_free) cmd.kind = CMD_DUMP_OUT;
      end
      default: cmd.kind = CMD_NONE;
    endcase
  end

endmodule

// ----- src/tkn_dp.sv -----
// Datapath: config registers, entry RAM, scan/compaction counters, result register.
// Depends on tkn_pkg, tkn_if, tkn_ram.
module tkn_dp import tkn_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  tkn_item_t    item,
  input  tkn_cmd_t     cmd,
  output tkn_status_t  sts,
  tkn_cfg_if.sink      cfg_ch,
  tkn_out_if.source    out_ch
);

  localparam int IDX_W = tkn_idx_bits(MAX_ENTRIES);
  localparam int CNT_W = tkn_cnt_bits(MAX_ENTRIES);
  localparam int LIM_W = (CNT_W > ROIS_W) ? CNT_W : ROIS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  logic signed [SCORE_W-1:0] min_score_r;
  logic [ROIS_W-1:0]         max_rois_r;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic                      out_valid_r;
  logic                      rv_r;
  logic [CNT_W-1:0]          rd_idx_r;
  logic [IDX_W-1:0]          ri_r;
  logic [1:0]                nb_r;
  logic [IDX_W-1:0]          first_r;
  logic signed [SCORE_W-1:0] worst_r;
  logic [IDX_W-1:0]          worst_id_r;
  logic                      have_worst_r;
  logic [IDX_W-1:0]          wr_ptr_r;
  logic [OP_W-1:0]           op_r;
  tkn_entry_t                cand_r;
  logic [ACT_W-1:0]          res_act_r;
  logic [IDX_W-1:0]          res_slot_r;

  logic [ACT_W-1:0]          out_act_r;
  logic [IDX_W-1:0]          out_slot_r;
  tkn_entry_t                out_ent_r;
  logic [CNT_W-1:0]          out_cnt_r;
  logic                      out_last_r;

  tkn_entry_t       rd_ent;
  tkn_entry_t       ram_wdata;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] place_slot;
  logic             ram_we, ram_re;
  logic             scan_rd, more_left, ov, beats, keep, out_free, load_out;

  tkn_ram #(
    .WIDTH ($bits(tkn_entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (rd_ent)
  );

  assign ov        = tkn_overlap(rd_ent.rect, cand_r.rect);
  assign beats     = rd_ent.score < cand_r.score;
  assign more_left = rd_idx_r < fill_r;
  assign scan_rd   = ((cmd.kind == CMD_SCAN) || (cmd.kind == CMD_COMPACT)) && more_left;
  assign ram_re    = scan_rd || (cmd.kind == CMD_DUMP_RD);
  // compaction: every overlapping entry was beaten, the rest slide down
  assign keep      = (cmd.kind == CMD_COMPACT) && rv_r && !ov;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign load_out  = (cmd.kind == CMD_EMIT) || (cmd.kind == CMD_DUMP_OUT);

  always_comb begin
    case (cmd.place)
      PL_APPEND: place_slot = fill_r[IDX_W-1:0];
      PL_WORST:  place_slot = worst_id_r;
      PL_FIRST:  place_slot = first_r;
      PL_MERGE:  place_slot = wr_ptr_r;
      default:   place_slot = fill_r[IDX_W-1:0];
    endcase
  end

  assign ram_we    = keep || (cmd.kind == CMD_PLACE);
  assign ram_waddr = keep ? wr_ptr_r : place_slot;
  assign ram_wdata = keep ? rd_ent : cand_r;

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.kind == CMD_CLEAR) begin
      fill_nxt = '0;
    end else if (cmd.kind == CMD_PLACE) begin
      if (cmd.place == PL_APPEND)     fill_nxt = fill_r + 1'b1;
      else if (cmd.place == PL_MERGE) fill_nxt = CNT_W'(wr_ptr_r) + 1'b1;
    end
  end

  always_comb begin
    sts.op            = op_r;
    sts.below_min     = cand_r.score < min_score_r;
    sts.dominated     = rv_r && ov && !beats;
    sts.pass_done     = !more_left && !rv_r;
    sts.none_beaten   = (nb_r == 2'd0);
    sts.one_beaten    = (nb_r == 2'd1);
    // limit is max_rois clamped to the table depth
    sts.fill_lt_limit = (LIM_W'(fill_r) < LIM_W'(max_rois_r)) && (fill_r < FULL_CNT);
    sts.have_worst    = have_worst_r;
    sts.fill_zero     = (fill_r == '0);
    sts.out_free      = out_free;
    sts.dump_last     = (rd_idx_r == fill_r);
  end

  assign cfg_ch.ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_score_r  <= MIN_SCORE_RST;
      max_rois_r   <= MAX_ROIS_RST;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      rv_r         <= 1'b0;
      rd_idx_r     <= '0;
      nb_r         <= 2'd0;
      have_worst_r <= 1'b0;
      wr_ptr_r     <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (tkn_reg_t'(cfg_ch.index))
          REG_MIN_SCORE: min_score_r <= cfg_ch.data;
          REG_MAX_ROIS:  max_rois_r  <= cfg_ch.data[ROIS_W-1:0];
          default:       max_rois_r  <= max_rois_r;
        endcase
      end
      fill_r <= fill_nxt;
      rv_r   <= scan_rd;
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cmd.kind == CMD_LOAD) begin
        rd_idx_r     <= '0;
        nb_r         <= 2'd0;
        have_worst_r <= 1'b0;
        wr_ptr_r     <= '0;
      end else if (cmd.kind == CMD_COMPACT_START) begin
        rd_idx_r <= '0;
        wr_ptr_r <= '0;
      end else begin
        if (ram_re) rd_idx_r <= rd_idx_r + 1'b1;
        if (keep)   wr_ptr_r <= wr_ptr_r + 1'b1;
        if ((cmd.kind == CMD_SCAN) && rv_r) begin
          if (ov && (nb_r != 2'd2)) nb_r <= nb_r + 1'b1;
          if (worst_r > rd_ent.score) have_worst_r <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.kind == CMD_LOAD) begin
      op_r    <= item.op;
      cand_r  <= item.cand;
      worst_r <= item.cand.score;
    end
    if (ram_re) ri_r <= rd_idx_r[IDX_W-1:0];
    if ((cmd.kind == CMD_SCAN) && rv_r) begin
      if (ov && (nb_r == 2'd0)) first_r <= ri_r;
      if (worst_r > rd_ent.score) begin
        worst_r    <= rd_ent.score;
        worst_id_r <= ri_r;
      end
    end
    if ((cmd.kind == CMD_RESULT) || (cmd.kind == CMD_CLEAR)) begin
      res_act_r  <= cmd.act;
      res_slot_r <= '0;
    end else if (cmd.kind == CMD_PLACE) begin
      res_act_r  <= cmd.act;
      res_slot_r <= place_slot;
    end
    if (cmd.kind == CMD_EMIT) begin
      out_act_r  <= res_act_r;
      out_slot_r <= res_slot_r;
      out_ent_r  <= '0;
      out_cnt_r  <= fill_r;
      out_last_r <= 1'b1;
    end else if (cmd.kind == CMD_DUMP_OUT) begin
      out_act_r  <= ACT_ENTRY;
      out_slot_r <= ri_r;
      out_ent_r  <= rd_ent;
      out_cnt_r  <= fill_r;
      out_last_r <= (rd_idx_r == fill_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = out_act_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.entry_score = out_ent_r.score;
  assign out_ch.entry_x     = out_ent_r.rect.x;
  assign out_ch.entry_y     = out_ent_r.rect.y;
  assign out_ch.entry_w     = out_ent_r.rect.w;
  assign out_ch.entry_h     = out_ent_r.rect.h;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.last        = out_last_r;

endmodule

// ----- src/top_k_nonoverlap_candidate_table_unit.sv -----
// Top level of the top-k non-overlapping candidate table (greedy NMS).
// Depends on tkn_pkg, tkn_if, tkn_ctrl, tkn_dp (which holds tkn_ram).
//
//  channel | dir | handshake     | item
//  --------+-----+---------------+----------------------------------------------
//  in_ch   | in  | valid/ready   | op, candidate score and rectangle
//  out_ch  | out | valid/ready   | action, slot, entry fields, count, last
//  cfg_ch  | in  | valid/ready   | register index (0 min_score, 1 max_rois), data
//
//  Reads: an offer makes one walk over the entry RAM's single read port, one
//  entry per cycle, or two walks when several overlapped entries are merged
//  away. A dump reads each entry only once the one before is loaded for output.
//  Reset: clears the fill count, the controller and the output valid and loads
//  the register defaults; entries are never cleared, only those below the fill
//  count are read.
//  Stalls: results sit in an output register; the next item is taken while it
//  waits. A held result stalls only the following result load.
module top_k_nonoverlap_candidate_table_unit import tkn_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tkn_in_if.sink     in_ch,
  tkn_out_if.source  out_ch,
  tkn_cfg_if.sink    cfg_ch
);

  localparam int CNT_W = tkn_cnt_bits(MAX_ENTRIES);

  tkn_cmd_t    cmd;
  tkn_status_t sts;
  tkn_item_t   item;
  logic        in_ready;
  logic        in_fire;

  always_comb begin
    item.op              = in_ch.op;
    item.cand.score      = in_ch.cand_score;
    item.cand.rect.x     = in_ch.cand_x;
    item.cand.rect.y     = in_ch.cand_y;
    item.cand.rect.w     = in_ch.cand_w;
    item.cand.rect.h     = in_ch.cand_h;
  end

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  // sequencer: one item at a time, from accept to its last result load
  tkn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table storage, scan/compaction logic and result register
  tkn_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // work on an item blocks the input for at least the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.entry_count <= CNT_W'(MAX_ENTRIES)))
    else $error("entry count above table depth");

  a_slot_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((out_ch.action == ACT_APPENDED) ||
                      (out_ch.action == ACT_REPLACED_WORST) ||
                      (out_ch.action == ACT_REPLACED_ONE) ||
                      (out_ch.action == ACT_MERGED) ||
                      (out_ch.action == ACT_ENTRY)))
    |-> (CNT_W'(out_ch.slot) < out_ch.entry_count))
    else $error("slot outside the filled table");

  a_quiet_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.action != ACT_ENTRY)) |->
    ((out_ch.entry_score == '0) && (out_ch.entry_x == '0) && (out_ch.entry_y == '0) &&
     (out_ch.entry_w == '0) && (out_ch.entry_h == '0) && out_ch.last))
    else $error("non-entry result carries entry data or lacks last");

endmodule
